### rtl/ple_pkg.sv
// Shared types and constants for the positional list engine.
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

	// Fixed field widths of the request and response channels.
	localparam int POS_W  = 5;
	localparam int DATA_W = 32;

	// Operation codes carried in the request opcode field.
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_LOCATE = 2'd2,
		OP_GET    = 2'd3
	} opcode_t;

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_INS_CHK,
		S_INS_RD,
		S_INS_WR,
		S_INS_PUT,
		S_RD_POS,
		S_CAPTURE,
		S_DEL_NEXT,
		S_DEL_RD,
		S_DEL_WR,
		S_LOC_RD,
		S_LOC_CMP,
		S_FINISH
	} state_t;

	// Read address sources.
	typedef enum logic [1:0] {
		RD_POS,
		RD_IDX,
		RD_IDX_M1,
		RD_IDX_P1
	} rd_sel_t;

	// Write address and data sources.
	typedef enum logic {
		WR_SHIFT,
		WR_KEY
	} wr_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    idx_inc;
		logic    idx_dec;
		logic    cap_elem;
		logic    cap_found;
		logic    count_inc;
		logic    count_dec;
		logic    result_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		opcode_t op;
		logic    ok;
		logic    more_up;
		logic    more_down;
		logic    count_zero;
		logic    match;
		logic    out_free;
	} status_t;

endpackage

`default_nettype wire

### rtl/ple_req_if.sv
// Request channel interface: opcode, position and value.
`timescale 1ns / 1ps
`default_nettype none

interface ple_req_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         opcode;
	logic [ple_pkg::POS_W-1:0]          position;
	logic signed [ple_pkg::DATA_W-1:0]  value;

	modport source (output valid, output opcode, output position, output value, input ready);
	modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

`default_nettype wire

### rtl/ple_rsp_if.sv
// Response channel interface: status, element, found position and list count.
`timescale 1ns / 1ps
`default_nettype none

interface ple_rsp_if;
	logic                               valid;
	logic                               ready;
	logic                               ok;
	logic signed [ple_pkg::DATA_W-1:0]  element;
	logic [ple_pkg::POS_W-1:0]          found_position;
	logic [ple_pkg::POS_W-1:0]          list_count;

	modport source (output valid, output ok, output element, output found_position,
		output list_count, input ready);
	modport sink   (input valid, input ok, input element, input found_position,
		input list_count, output ready);
endinterface

`default_nettype wire

### rtl/ple_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ple_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                        clk,
	input  wire logic                                        we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                            wdata,
	input  wire logic                                        re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/ple_ctrl.sv
// Controller state machine that sequences list operations over the entry RAM.
`timescale 1ns / 1ps
`default_nettype none

module ple_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire ple_pkg::status_t status,
	output ple_pkg::cmd_t         cmd
);

	ple_pkg::state_t state_q;
	ple_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ple_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ple_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ple_pkg::S_DECODE;
				end
			end
			ple_pkg::S_DECODE: begin
				if (!status.ok) begin
					state_d = ple_pkg::S_FINISH;
				end else begin
					case (status.op)
						ple_pkg::OP_INSERT: state_d = ple_pkg::S_INS_CHK;
						ple_pkg::OP_LOCATE: begin
							state_d = status.count_zero ? ple_pkg::S_FINISH : ple_pkg::S_LOC_RD;
						end
						default: state_d = ple_pkg::S_RD_POS;
					endcase
				end
			end
			// Insert: move entries up one cell at a time from the tail.
			ple_pkg::S_INS_CHK: begin
				state_d = status.more_up ? ple_pkg::S_INS_RD : ple_pkg::S_INS_PUT;
			end
			ple_pkg::S_INS_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = ple_pkg::RD_IDX_M1;
				state_d    = ple_pkg::S_INS_WR;
			end
			ple_pkg::S_INS_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = ple_pkg::WR_SHIFT;
				cmd.idx_dec = 1'b1;
				state_d     = ple_pkg::S_INS_CHK;
			end
			ple_pkg::S_INS_PUT: begin
				cmd.wr_en     = 1'b1;
				cmd.wr_sel    = ple_pkg::WR_KEY;
				cmd.count_inc = 1'b1;
				state_d       = ple_pkg::S_FINISH;
			end
			// Delete and get: fetch the addressed entry.
			ple_pkg::S_RD_POS: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = ple_pkg::RD_POS;
				state_d    = ple_pkg::S_CAPTURE;
			end
			ple_pkg::S_CAPTURE: begin
				cmd.cap_elem = 1'b1;
				state_d = (status.op == ple_pkg::OP_DELETE) ? ple_pkg::S_DEL_NEXT
					: ple_pkg::S_FINISH;
			end
			// Delete: move later entries down one cell at a time.
			ple_pkg::S_DEL_NEXT: begin
				if (status.more_down) begin
					state_d = ple_pkg::S_DEL_RD;
				end else begin
					cmd.count_dec = 1'b1;
					state_d       = ple_pkg::S_FINISH;
				end
			end
			ple_pkg::S_DEL_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = ple_pkg::RD_IDX_P1;
				state_d    = ple_pkg::S_DEL_WR;
			end
			ple_pkg::S_DEL_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = ple_pkg::WR_SHIFT;
				cmd.idx_inc = 1'b1;
				state_d     = ple_pkg::S_DEL_NEXT;
			end
			// Locate: scan from the head until the first match.
			ple_pkg::S_LOC_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = ple_pkg::RD_IDX;
				state_d    = ple_pkg::S_LOC_CMP;
			end
			ple_pkg::S_LOC_CMP: begin
				if (status.match) begin
					cmd.cap_found = 1'b1;
					state_d       = ple_pkg::S_FINISH;
				end else if (status.more_down) begin
					cmd.idx_inc = 1'b1;
					state_d     = ple_pkg::S_LOC_RD;
				end else begin
					state_d = ple_pkg::S_FINISH;
				end
			end
			// Hand the result to the output register once it is free.
			ple_pkg::S_FINISH: begin
				if (status.out_free) begin
					cmd.result_load = 1'b1;
					state_d         = ple_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ple_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/ple_datapath.sv
// Datapath: operation registers, index and count, entry RAM and result register.
`timescale 1ns / 1ps
`default_nettype none

module ple_datapath #(
	parameter int CAPACITY   = 16,
	parameter int ELEM_WIDTH = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [1:0]                        opcode,
	input  wire logic [ple_pkg::POS_W-1:0]         position,
	input  wire logic signed [ple_pkg::DATA_W-1:0] value,
	input  wire ple_pkg::cmd_t                     cmd,
	output ple_pkg::status_t                       status,
	input  wire logic                              out_ready,
	output logic                                   out_valid,
	output logic                                   out_ok,
	output logic signed [ple_pkg::DATA_W-1:0]      out_element,
	output logic [ple_pkg::POS_W-1:0]              out_found,
	output logic [ple_pkg::POS_W-1:0]              out_count
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CMPW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;

	ple_pkg::opcode_t               op_q;
	logic                           ok_q;
	logic [ple_pkg::POS_W-1:0]      posm1_q;
	logic [ELEM_WIDTH-1:0]          key_q;
	logic [CW-1:0]                  idx_q;
	logic [CW-1:0]                  count_q;
	logic signed [ple_pkg::DATA_W-1:0] elem_q;
	logic [ple_pkg::POS_W-1:0]      found_q;

	logic                           out_valid_q;
	logic                           rsp_ok_q;
	logic signed [ple_pkg::DATA_W-1:0] rsp_elem_q;
	logic [ple_pkg::POS_W-1:0]      rsp_found_q;
	logic [ple_pkg::POS_W-1:0]      rsp_count_q;

	ple_pkg::opcode_t               op_in;
	logic [ple_pkg::POS_W-1:0]      pos_m1;
	logic [CMPW-1:0]                pos_c;
	logic [CMPW-1:0]                cnt_c;
	logic                           pos_in_list;
	logic                           ins_ok;
	logic                           ok_d;
	logic [CW-1:0]                  idx_init;
	logic [CW-1:0]                  idx_m1;
	logic [CW-1:0]                  idx_p1;

	logic                           ram_we;
	logic [AW-1:0]                  ram_waddr;
	logic [ELEM_WIDTH-1:0]          ram_wdata;
	logic [AW-1:0]                  ram_raddr;
	logic [ELEM_WIDTH-1:0]          ram_rdata;

	// Bound checks on the incoming request against the current length.
	assign op_in       = ple_pkg::opcode_t'(opcode);
	assign pos_m1      = position - ple_pkg::POS_W'(1);
	assign pos_c       = CMPW'(position);
	assign cnt_c       = CMPW'(count_q);
	assign pos_in_list = (pos_c != '0) && (pos_c <= cnt_c);
	assign ins_ok      = (pos_c != '0) && (pos_c <= cnt_c + CMPW'(1))
		&& (count_q < CW'(CAPACITY));

	always_comb begin
		case (op_in)
			ple_pkg::OP_INSERT: begin
				ok_d     = ins_ok;
				idx_init = count_q;
			end
			ple_pkg::OP_LOCATE: begin
				ok_d     = 1'b1;
				idx_init = '0;
			end
			default: begin
				ok_d     = pos_in_list;
				idx_init = CW'(pos_m1);
			end
		endcase
	end

	// Operation registers, captured when a request transfer is taken.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_in;
			ok_q    <= ok_d;
			posm1_q <= pos_m1;
			key_q   <= ELEM_WIDTH'(value);
		end
	end

	// Walking index and captured element and match position.
	assign idx_m1 = idx_q - CW'(1);
	assign idx_p1 = idx_q + CW'(1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q   <= idx_init;
			elem_q  <= '0;
			found_q <= '0;
		end else begin
			if (cmd.idx_inc) begin
				idx_q <= idx_p1;
			end else if (cmd.idx_dec) begin
				idx_q <= idx_m1;
			end
			if (cmd.cap_elem) begin
				elem_q <= ple_pkg::DATA_W'(signed'(ram_rdata));
			end
			if (cmd.cap_found) begin
				found_q <= ple_pkg::POS_W'(idx_p1);
			end
		end
	end

	// List length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.count_inc) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.count_dec) begin
			count_q <= count_q - CW'(1);
		end
	end

	// Entry RAM addressing.
	always_comb begin
		case (cmd.rd_sel)
			ple_pkg::RD_POS:    ram_raddr = AW'(posm1_q);
			ple_pkg::RD_IDX:    ram_raddr = idx_q[AW-1:0];
			ple_pkg::RD_IDX_M1: ram_raddr = idx_m1[AW-1:0];
			ple_pkg::RD_IDX_P1: ram_raddr = idx_p1[AW-1:0];
			default:            ram_raddr = idx_q[AW-1:0];
		endcase
	end

	assign ram_we    = cmd.wr_en;
	assign ram_waddr = (cmd.wr_sel == ple_pkg::WR_KEY) ? AW'(posm1_q) : idx_q[AW-1:0];
	assign ram_wdata = (cmd.wr_sel == ple_pkg::WR_KEY) ? key_q : ram_rdata;

	ple_ram #(
		.WIDTH (ELEM_WIDTH),
		.DEPTH (CAPACITY)
	) u_entries (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Status for the controller.
	assign status.op         = op_q;
	assign status.ok         = ok_q;
	assign status.more_up    = CMPW'(idx_q) > CMPW'(posm1_q);
	assign status.more_down  = (CMPW'(idx_q) + CMPW'(1)) < cnt_c;
	assign status.count_zero = (count_q == '0);
	assign status.match      = (ram_rdata == key_q);
	assign status.out_free   = !out_valid_q || out_ready;

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.result_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			rsp_ok_q    <= ok_q;
			rsp_elem_q  <= elem_q;
			rsp_found_q <= found_q;
			rsp_count_q <= ple_pkg::POS_W'(count_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign out_ok      = rsp_ok_q;
	assign out_element = rsp_elem_q;
	assign out_found   = rsp_found_q;
	assign out_count   = rsp_count_q;

endmodule

`default_nettype wire

### rtl/positional_list_engine_core.sv
// Top level of the positional list engine: controller, datapath and channel ports.
`timescale 1ns / 1ps
`default_nettype none

// The engine keeps an ordered list of up to CAPACITY signed entries in a
// single-port-per-direction RAM, together with a length count, and answers
// one request at a time with exactly one response. The entry RAM is read and
// written one cell at a time while the controller walks the list. A new
// request is taken as soon as the previous result sits in the output
// register, even if that result has not yet been transferred. Entries beyond
// the current length are never read, so the RAM needs no clearing after reset.
module positional_list_engine_core #(
	parameter int CAPACITY   = 16,
	parameter int ELEM_WIDTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	ple_req_if.sink   request,
	ple_rsp_if.source response
);

	ple_pkg::cmd_t    cmd;
	ple_pkg::status_t status;

	// Sequencing of each operation.
	ple_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_ready (request.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Storage, bound checks and the output register.
	ple_datapath #(
		.CAPACITY   (CAPACITY),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.opcode      (request.opcode),
		.position    (request.position),
		.value       (request.value),
		.cmd         (cmd),
		.status      (status),
		.out_ready   (response.ready),
		.out_valid   (response.valid),
		.out_ok      (response.ok),
		.out_element (response.element),
		.out_found   (response.found_position),
		.out_count   (response.list_count)
	);

endmodule

`default_nettype wire
